// File: rtl/jbps_pkg.sv
`timescale 1ns / 1ps

package jbps_pkg;

    // fixed widths of the item fields
    localparam int unsigned CODE_W      = 24;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PEND_W      = 7;
    localparam int unsigned PEND_CNT_W  = 3;
    localparam int unsigned RES_CNT_W   = 3;

    localparam logic [BYTE_W-1:0]    BYTE_ALL_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0]    BYTE_STUFF    = 8'h00;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS   = 3'd7;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] code_value;
        logic [COUNT_W-1:0] bit_count;
        logic              marker_flag;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_DATA,
        ST_STUFF
    } state_t;

    typedef enum logic [1:0] {
        SRC_FLUSH,
        SRC_DATA,
        SRC_STUFF
    } byte_src_t;

    // controller to datapath
    typedef struct packed {
        logic      accept;
        logic      emit;
        byte_src_t src;
        logic      last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_flush;
        logic k_zero;
        logic k_one;
        logic at_cap;
        logic data_stuff;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/jbps_in_if.sv
`timescale 1ns / 1ps

interface jbps_in_if;
    logic               valid;
    logic               ready;
    jbps_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/jbps_out_if.sv
`timescale 1ns / 1ps

interface jbps_out_if;
    logic                valid;
    logic                ready;
    jbps_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/jbps_ctrl.sv
`timescale 1ns / 1ps

module jbps_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jbps_pkg::dp_status_t st,
    output jbps_pkg::dp_cmd_t    cmd
);

    jbps_pkg::state_t state_reg;
    jbps_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jbps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jbps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = jbps_pkg::ST_FLUSH;
                end
            end
            jbps_pkg::ST_FLUSH:
            begin
                if (!st.has_flush)
                begin
                    state_next = st.k_zero ? jbps_pkg::ST_IDLE : jbps_pkg::ST_DATA;
                end
                else if (st.out_free)
                begin
                    state_next = (st.k_zero || st.at_cap) ? jbps_pkg::ST_IDLE
                                                          : jbps_pkg::ST_DATA;
                end
            end
            jbps_pkg::ST_DATA:
            begin
                if (st.out_free)
                begin
                    priority if (st.at_cap || (st.k_one && !st.data_stuff))
                    begin
                        state_next = jbps_pkg::ST_IDLE;
                    end
                    else if (st.data_stuff)
                    begin
                        state_next = jbps_pkg::ST_STUFF;
                    end
                    else
                    begin
                        state_next = jbps_pkg::ST_DATA;
                    end
                end
            end
            jbps_pkg::ST_STUFF:
            begin
                if (st.out_free)
                begin
                    state_next = (st.k_zero || st.at_cap) ? jbps_pkg::ST_IDLE
                                                          : jbps_pkg::ST_DATA;
                end
            end
            default:
            begin
                state_next = jbps_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        cmd.src    = jbps_pkg::SRC_FLUSH;
        cmd.last   = 1'b0;
        unique case (state_reg)
            jbps_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            jbps_pkg::ST_FLUSH:
            begin
                cmd.emit = st.has_flush && st.out_free;
                cmd.src  = jbps_pkg::SRC_FLUSH;
                cmd.last = st.k_zero || st.at_cap;
            end
            jbps_pkg::ST_DATA:
            begin
                cmd.emit = st.out_free;
                cmd.src  = jbps_pkg::SRC_DATA;
                cmd.last = st.at_cap || (st.k_one && !st.data_stuff);
            end
            jbps_pkg::ST_STUFF:
            begin
                cmd.emit = st.out_free;
                cmd.src  = jbps_pkg::SRC_STUFF;
                cmd.last = st.k_zero || st.at_cap;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/jbps_datapath.sv
`timescale 1ns / 1ps

module jbps_datapath
#(
    parameter int unsigned MAX_CODE_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  jbps_pkg::in_item_t   item,
    input  jbps_pkg::dp_cmd_t    cmd,
    output jbps_pkg::dp_status_t st,
    input  logic                 out_ready,
    output logic                 out_valid,
    output jbps_pkg::out_item_t  out_item
);

    localparam int unsigned ACC_W     = MAX_CODE_BITS + jbps_pkg::PEND_W;
    localparam int unsigned BYTES_MAX = ACC_W / 8;
    localparam int unsigned TOT_W     = $clog2(ACC_W + 1);
    localparam int unsigned K_W       = $clog2(BYTES_MAX + 1);
    localparam int unsigned IDX_W     = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;

    logic [jbps_pkg::PEND_W-1:0]     pend_bits_reg, pend_bits_next;
    logic [jbps_pkg::PEND_CNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic [BYTES_MAX-1:0][7:0]       word_reg, word_next;
    logic [K_W-1:0]                  k_reg, k_next;
    logic [jbps_pkg::BYTE_W-1:0]     flush_byte_reg, flush_byte_next;
    logic                            has_flush_reg, has_flush_next;
    logic                            mk_reg;
    logic [jbps_pkg::RES_CNT_W-1:0]  n_reg;
    logic                            out_valid_reg;
    jbps_pkg::out_item_t             out_item_reg, out_item_next;

    logic [jbps_pkg::COUNT_W-1:0]    cnt_clamp;
    logic                            pre_flush;
    logic [jbps_pkg::PEND_W-1:0]     eff_bits;
    logic [jbps_pkg::PEND_CNT_W-1:0] eff_cnt;
    logic [ACC_W-1:0]                acc;
    logic [TOT_W-1:0]                total;
    logic [2:0]                      rem;
    logic [ACC_W-1:0]                rem_mask;
    logic [IDX_W-1:0]                k_idx;
    logic [jbps_pkg::BYTE_W-1:0]     data_byte;

    // clamp the code length and splice it behind the pending bits
    always_comb
    begin
        cnt_clamp = (item.bit_count > jbps_pkg::COUNT_W'(MAX_CODE_BITS))
                  ? jbps_pkg::COUNT_W'(MAX_CODE_BITS) : item.bit_count;
        pre_flush = item.marker_flag && (pend_bits_reg > 7'd1);
        eff_bits  = pre_flush ? '0 : pend_bits_reg;
        eff_cnt   = pre_flush ? '0 : pend_cnt_reg;
        acc       = (ACC_W'(eff_bits) << cnt_clamp)
                  | (ACC_W'(item.code_value) & ((ACC_W'(1) << cnt_clamp) - ACC_W'(1)));
        total     = TOT_W'(eff_cnt) + TOT_W'(cnt_clamp);
        rem       = total[2:0];
        rem_mask  = (ACC_W'(1) << rem) - ACC_W'(1);
    end

    // values loaded when an item is accepted
    always_comb
    begin
        flush_byte_next = 8'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg}));
        if (item.mode)
        begin
            has_flush_next = (pend_cnt_reg != '0);
            pend_bits_next = '0;
            pend_cnt_next  = '0;
            word_next      = '0;
            k_next         = '0;
        end
        else
        begin
            has_flush_next = pre_flush && (pend_cnt_reg != '0);
            pend_bits_next = jbps_pkg::PEND_W'(acc & rem_mask);
            pend_cnt_next  = rem;
            word_next      = (BYTES_MAX * 8)'(acc >> rem);
            k_next         = K_W'(total >> 3);
        end
    end

    // byte selection for the result register
    always_comb
    begin
        k_idx     = IDX_W'(k_reg - K_W'(1));
        data_byte = word_reg[k_idx];
        out_item_next.last = cmd.last;
        unique case (cmd.src)
            jbps_pkg::SRC_FLUSH: out_item_next.out_byte = flush_byte_reg;
            jbps_pkg::SRC_DATA:  out_item_next.out_byte = data_byte;
            jbps_pkg::SRC_STUFF: out_item_next.out_byte = jbps_pkg::BYTE_STUFF;
            default:             out_item_next.out_byte = jbps_pkg::BYTE_STUFF;
        endcase
    end

    // status to the controller
    always_comb
    begin
        st.has_flush  = has_flush_reg;
        st.k_zero     = (k_reg == '0);
        st.k_one      = (k_reg == K_W'(1));
        st.at_cap     = (n_reg == jbps_pkg::MAX_RESULTS - 3'd1);
        st.data_stuff = (data_byte == jbps_pkg::BYTE_ALL_ONES) && !mk_reg;
        st.out_free   = !out_valid_reg || out_ready;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            k_reg         <= '0;
            has_flush_reg <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pend_bits_reg <= pend_bits_next;
                pend_cnt_reg  <= pend_cnt_next;
                k_reg         <= k_next;
                has_flush_reg <= has_flush_next;
                n_reg         <= '0;
            end
            else if (cmd.emit)
            begin
                n_reg <= n_reg + 3'd1;
                if (cmd.src == jbps_pkg::SRC_DATA)
                begin
                    k_reg <= k_reg - K_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg       <= word_next;
            flush_byte_reg <= flush_byte_next;
            mk_reg         <= item.marker_flag;
        end
        if (cmd.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/jpeg_bit_packer_stuffing.sv
`timescale 1ns / 1ps
// channel | role   | payload                                  | accepted when
// codes   | sink   | mode, code_value, bit_count, marker_flag | valid && ready
// stream  | source | out_byte, last                           | valid && ready
//
// one item is taken at a time: the sequencer accepts it, then sends the
// flush byte or idles, then sends each further result byte (up to six).
// the single result register is loaded one byte a cycle, unless stream
// stalls. rst_n clears the pending bits and the sequencer asynchronously.
// a stall on stream holds the sequencer; the next item is taken while the
// final result still waits in the output register.

module jpeg_bit_packer_stuffing
#(
    parameter int unsigned MAX_CODE_BITS = 24
)
(
    input logic         clk,
    input logic         rst_n,
    jbps_in_if.sink     codes,
    jbps_out_if.source  stream
);

    jbps_pkg::dp_cmd_t    cmd;
    jbps_pkg::dp_status_t st;

    // sequencer
    jbps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (codes.valid),
        .in_ready (codes.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // bit accumulator and result register
    jbps_datapath
    #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (codes.data),
        .cmd       (cmd),
        .st        (st),
        .out_ready (stream.ready),
        .out_valid (stream.valid),
        .out_item  (stream.data)
    );

endmodule

// File: rtl/jbps_checker.sv
`timescale 1ns / 1ps

module jbps_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input jbps_pkg::out_item_t out_item
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stream item changed while stalled");

    // no new code item while results of the current one are still coming
    a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> !in_ready)
        else $error("codes ready before the last result");

    // a result only appears out of a busy cycle
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared from an idle cycle");

endmodule

bind jpeg_bit_packer_stuffing jbps_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (codes.ready),
    .out_valid (stream.valid),
    .out_ready (stream.ready),
    .out_item  (stream.data)
);
